// File: src/kvi_pkg.sv
// Shared types and constants for the keyframe vec3 interpolator.
package kvi_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned NUM_C   = 3;

  // Request kinds carried on req_type
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SRCH,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } kvi_state_t;

  typedef logic [NUM_C-1:0][VAL_W-1:0] kvi_vec_t;

  // One keyframe as held in the table
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    kvi_vec_t           vec;
  } kvi_entry_t;

endpackage

// File: src/keyframe_vec3_interpolator.sv
// Keyframe vec3 linear interpolator: table, segment search, divider and blend.
// Write request: no response. Sample request: reads the first and last keys, searches the
// table for the segment, runs FRAC_BITS divide steps and blends each component, then raises
// rsp_valid; the divide is skipped when not needed, and a single key answers from entry 0.
// One request is in flight; the next is taken the cycle after the response is accepted.
// Reset (rst, synchronous): sequencer idle, num_keys = 1; the key table is not cleared.
module keyframe_vec3_interpolator #(
  parameter int unsigned MAX_KEYS  = 64,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CNT_W-1:0]            cfg_data,
  // request channel
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        req_type,
  input  logic [IDX_W-1:0]            key_index,
  input  logic [kvi_pkg::STAMP_W-1:0] key_stamp,
  input  logic signed [kvi_pkg::VAL_W-1:0] key_x,
  input  logic signed [kvi_pkg::VAL_W-1:0] key_y,
  input  logic signed [kvi_pkg::VAL_W-1:0] key_z,
  input  logic [kvi_pkg::STAMP_W-1:0] sample_time,
  // response channel
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic signed [kvi_pkg::VAL_W-1:0] out_x,
  output logic signed [kvi_pkg::VAL_W-1:0] out_y,
  output logic signed [kvi_pkg::VAL_W-1:0] out_z,
  output logic [IDX_W-1:0]            segment,
  output logic                        clamped
);
  import kvi_pkg::*;

  localparam int unsigned F_W   = FRAC_BITS + 1;
  localparam int unsigned DIV_W = $clog2(FRAC_BITS + 1);
  localparam int unsigned PRD_W = VAL_W + 1 + FRAC_BITS + 2;

  kvi_state_t state, state_next;

  // Key table
  kvi_entry_t mem [MAX_KEYS];
  kvi_entry_t rd_data;
  logic [IDX_W-1:0] rd_addr;

  // Control and datapath registers
  logic [CNT_W-1:0]   num_keys;
  logic [STAMP_W-1:0] t;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   seg;
  logic               clamp_lo;
  logic               clamp_flag;
  logic               found;
  kvi_entry_t         lo;
  kvi_entry_t         hi;
  logic [STAMP_W-1:0] rem;
  logic [STAMP_W-1:0] den;
  logic [F_W-1:0]     f;
  logic [DIV_W-1:0]   cnt;
  logic [1:0]         comp;
  logic signed [PRD_W-1:0] prod;
  kvi_vec_t           res;

  // Combinational helpers
  logic               req_acc;
  logic [IDX_W-1:0]   last_idx_next;
  logic               hit;
  logic               srch_end;
  logic               need_div;
  logic               flat;
  logic [STAMP_W:0]   rem2;
  logic [STAMP_W:0]   diff;
  logic               ge;
  logic signed [VAL_W:0]   dlt;
  logic signed [F_W:0]     fs;
  logic signed [PRD_W-1:0] shifted;
  logic [VAL_W-1:0]        sum;

  assign req_acc   = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  // Effective last key index: zero count acts as one, large counts clip to the table
  always_comb begin
    priority if (num_keys == '0) begin
      last_idx_next = '0;
    end else if (num_keys > CNT_W'(MAX_KEYS)) begin
      last_idx_next = IDX_W'(MAX_KEYS - 1);
    end else begin
      last_idx_next = IDX_W'(num_keys - 1'b1);
    end
  end

  // Segment probe and fraction decisions
  assign hit      = t < rd_data.stamp;
  assign srch_end = hit || (ptr == last_idx);
  assign flat     = (hi.stamp <= rd_data.stamp) || (t <= rd_data.stamp);
  assign need_div = found && !flat;

  // Restoring divide step
  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, den};
  assign ge   = !diff[STAMP_W];

  // Shared blend multiplier operands and accumulate
  assign dlt     = $signed({hi.vec[comp][VAL_W-1], hi.vec[comp]})
                 - $signed({lo.vec[comp][VAL_W-1], lo.vec[comp]});
  assign fs      = $signed({1'b0, f});
  assign shifted = prod >>> FRAC_BITS;
  assign sum     = lo.vec[comp] + shifted[VAL_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc && req_type == REQ_SAMPLE) state_next = ST_FIRST;
      end
      ST_FIRST: begin
        state_next = (last_idx == '0) ? ST_OUT : ST_LAST;
      end
      ST_LAST: state_next = ST_SRCH;
      ST_SRCH: begin
        if (srch_end) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = need_div ? ST_DIV : ST_MUL;
      ST_DIV: begin
        if (cnt == DIV_W'(1)) state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = (comp == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT: begin
        if (!rsp_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs and table read address
  always_comb begin
    req_stall = (state != ST_IDLE);
    rsp_valid = (state == ST_OUT);
    rd_addr   = '0;
    unique case (state)
      ST_IDLE:  rd_addr = '0;
      ST_FIRST: rd_addr = last_idx;
      ST_LAST:  rd_addr = IDX_W'(1);
      ST_SRCH:  rd_addr = srch_end ? IDX_W'(ptr - 1'b1) : IDX_W'(ptr + 1'b1);
      default:  rd_addr = '0;
    endcase
  end

  assign out_x   = res[0];
  assign out_y   = res[1];
  assign out_z   = res[2];
  assign segment = seg;
  assign clamped = clamp_flag;

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (req_acc && req_type == REQ_WRITE && 32'(key_index) < MAX_KEYS) begin
      mem[key_index] <= '{stamp: key_stamp, vec: {key_z, key_y, key_x}};
    end
    rd_data <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      num_keys <= CNT_W'(1);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) num_keys <= cfg_data;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          t        <= sample_time;
          last_idx <= last_idx_next;
        end
      end
      ST_FIRST: begin
        // entry 0 arrives: low clamp, or the whole answer for a single key
        clamp_lo <= t < rd_data.stamp;
        if (last_idx == '0) begin
          res        <= rd_data.vec;
          seg        <= '0;
          clamp_flag <= t != rd_data.stamp;
        end
      end
      ST_LAST: begin
        clamp_flag <= clamp_lo || (t > rd_data.stamp);
        ptr        <= IDX_W'(1);
      end
      ST_SRCH: begin
        if (srch_end) begin
          hi    <= rd_data;
          found <= hit;
          seg   <= IDX_W'(ptr - 1'b1);
        end else begin
          ptr <= IDX_W'(ptr + 1'b1);
        end
      end
      ST_LOAD: begin
        lo   <= rd_data;
        comp <= 2'd0;
        rem  <= t - rd_data.stamp;
        den  <= hi.stamp - rd_data.stamp;
        cnt  <= DIV_W'(FRAC_BITS);
        // past the last key: full fraction; degenerate gap: lower key
        f    <= found ? '0 : {1'b1, {FRAC_BITS{1'b0}}};
      end
      ST_DIV: begin
        rem <= ge ? diff[STAMP_W-1:0] : rem2[STAMP_W-1:0];
        f   <= {f[F_W-2:0], ge};
        cnt <= DIV_W'(cnt - 1'b1);
      end
      ST_MUL: begin
        prod <= PRD_W'(dlt * fs);
      end
      ST_ADD: begin
        res[comp] <= sum;
        comp      <= 2'(comp + 1'b1);
      end
      ST_OUT: begin
        // hold response until taken
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request accepted while response pending");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req_type == REQ_SAMPLE) |=> (state == ST_FIRST))
    else $error("sample request did not start the sequencer");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH) |-> (ptr <= last_idx && ptr != '0))
    else $error("search pointer outside key range");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD && comp == 2'd2) |=> (state == ST_OUT))
    else $error("blend did not finish into response");
`endif

endmodule
